// ===== sv/swmm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared constants, types and the controller/datapath command and status words
// for the sliding window min/max block. No dependencies.
package swmm_pkg;

   localparam int WINDOW_MAX = 64;
   localparam int DATA_W     = 32;
   localparam int POS_W      = 16;
   localparam int WIN_W      = 7;
   localparam int IDX_W      = $clog2(WINDOW_MAX);
   localparam int CNT_W      = IDX_W + 1;
   localparam int ENTRY_W    = DATA_W + POS_W;
   // both deques share one RAM: the deque select is the top address bit
   localparam int RAM_DEPTH  = 2 * WINDOW_MAX;

   typedef enum logic {
      DQ_MIN = 1'b0,
      DQ_MAX = 1'b1
   } dq_sel_type;

   typedef struct packed {
      logic       accept;
      logic       rd_head;
      logic       rd_tail;
      logic       pop_head;
      logic       pop_tail;
      logic       push;
      logic       cap_front;
      logic       finish;
      dq_sel_type dsel;
   } swmm_cmd_type;

   typedef struct packed {
      logic empty;
      logic too_old;
      logic dominated;
      logic out_free;
   } swmm_status_type;

endpackage

`default_nettype wire

// ===== sv/swmm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module swmm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/swmm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Sequencer for the sliding window min/max block: walks each deque through
// front eviction, tail popping, append and front read. Depends on swmm_pkg.
module swmm_ctrl import swmm_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output      logic            req_tready,
   input  wire swmm_status_type status,
   output      swmm_cmd_type    cmd
);

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_EREQ = 9'b000000010,
      S_ECHK = 9'b000000100,
      S_TREQ = 9'b000001000,
      S_TCHK = 9'b000010000,
      S_PUSH = 9'b000100000,
      S_FREQ = 9'b001000000,
      S_FCHK = 9'b010000000,
      S_DONE = 9'b100000000
   } state_type;

   state_type  state_ff, state_in;
   dq_sel_type dsel_ff, dsel_in;

   always_comb begin
      state_in = state_ff;
      dsel_in  = dsel_ff;
      cmd      = '0;
      cmd.dsel = dsel_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               dsel_in    = DQ_MIN;
               state_in   = S_EREQ;
            end
         end
         S_EREQ: begin
            cmd.rd_head = 1'b1;
            state_in    = S_ECHK;
         end
         S_ECHK: begin
            // drop front entries that have aged out of the window
            if (!status.empty && status.too_old) begin
               cmd.pop_head = 1'b1;
               state_in     = S_EREQ;
            end else begin
               state_in = S_TREQ;
            end
         end
         S_TREQ: begin
            cmd.rd_tail = 1'b1;
            state_in    = S_TCHK;
         end
         S_TCHK: begin
            // drop tail entries that the new word dominates
            if (!status.empty && status.dominated) begin
               cmd.pop_tail = 1'b1;
               state_in     = S_TREQ;
            end else begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            cmd.push = 1'b1;
            state_in = S_FREQ;
         end
         S_FREQ: begin
            cmd.rd_head = 1'b1;
            state_in    = S_FCHK;
         end
         S_FCHK: begin
            cmd.cap_front = 1'b1;
            if (dsel_ff == DQ_MIN) begin
               dsel_in  = DQ_MAX;
               state_in = S_EREQ;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the output register can take the word
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dsel_ff  <= DQ_MIN;
      end else begin
         state_ff <= state_in;
         dsel_ff  <= dsel_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/swmm_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Datapath: circular deques in a shared RAM, positions, fill count, window
// register and output register. Depends on swmm_pkg and swmm_ram.
module swmm_datapath import swmm_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire swmm_cmd_type        cmd,
   output      swmm_status_type     status,
   input  wire logic [DATA_W-1:0]   req_tdata,
   input  wire logic                req_tuser,
   output      logic                rsp_tvalid,
   input  wire logic                rsp_tready,
   output      logic [2*DATA_W-1:0] rsp_tdata,
   input  wire logic                csr_wr_en,
   input  wire logic [WIN_W-1:0]    csr_wr_data
);

   logic [IDX_W-1:0]         head_ff [2];
   logic [IDX_W-1:0]         head_in [2];
   logic [CNT_W-1:0]         count_ff [2];
   logic [CNT_W-1:0]         count_in [2];
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic [CNT_W-1:0]         fill_ff, fill_in;
   logic [WIN_W-1:0]         win_ff, win_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] sample_ff;
   logic signed [DATA_W-1:0] front_ff [2];
   logic [2*DATA_W-1:0]      rsp_data_ff;

   logic [CNT_W-1:0]         win_eff;
   logic [CNT_W-1:0]         fill_next;
   logic                     produce;
   logic [IDX_W-1:0]         rd_idx;
   logic [IDX_W-1:0]         wr_idx;
   logic [ENTRY_W-1:0]       rd_entry;
   logic signed [DATA_W-1:0] rd_val;
   logic [POS_W-1:0]         rd_pos;
   logic [POS_W-1:0]         age;

   always_comb begin
      if (win_ff == '0) begin
         win_eff = CNT_W'(1);
      end else if (int'(win_ff) > WINDOW_MAX) begin
         win_eff = CNT_W'(WINDOW_MAX);
      end else begin
         win_eff = CNT_W'(win_ff);
      end
   end

   assign fill_next = (int'(fill_ff) == WINDOW_MAX) ? fill_ff : fill_ff + CNT_W'(1);
   assign produce   = (fill_next >= win_eff);

   // tail sits one below head + count, modulo the deque depth
   always_comb begin
      if (cmd.rd_tail) begin
         rd_idx = head_ff[cmd.dsel] + count_ff[cmd.dsel][IDX_W-1:0] - IDX_W'(1);
      end else begin
         rd_idx = head_ff[cmd.dsel];
      end
   end
   assign wr_idx = head_ff[cmd.dsel] + count_ff[cmd.dsel][IDX_W-1:0];

   swmm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr ({cmd.dsel, wr_idx}),
      .wr_data ({pos_ff, sample_ff}),
      .rd_addr ({cmd.dsel, rd_idx}),
      .rd_data (rd_entry)
   );

   assign rd_val = rd_entry[DATA_W-1:0];
   assign rd_pos = rd_entry[ENTRY_W-1:DATA_W];
   assign age    = pos_ff - rd_pos;

   always_comb begin
      status.empty    = (count_ff[cmd.dsel] == '0);
      status.too_old  = (age >= POS_W'(win_eff));
      if (cmd.dsel == DQ_MIN) begin
         status.dominated = (rd_val >= sample_ff);
      end else begin
         status.dominated = (rd_val <= sample_ff);
      end
      status.out_free = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      fill_in      = fill_ff;
      win_in       = win_ff;
      rsp_valid_in = rsp_valid_ff;
      if (csr_wr_en) begin
         win_in = csr_wr_data;
      end
      if (cmd.accept && req_tuser) begin
         count_in[DQ_MIN] = '0;
         count_in[DQ_MAX] = '0;
         pos_in           = '0;
         fill_in          = '0;
      end
      if (cmd.pop_head) begin
         head_in[cmd.dsel]  = head_ff[cmd.dsel] + IDX_W'(1);
         count_in[cmd.dsel] = count_ff[cmd.dsel] - CNT_W'(1);
      end
      if (cmd.pop_tail) begin
         count_in[cmd.dsel] = count_ff[cmd.dsel] - CNT_W'(1);
      end
      if (cmd.push) begin
         count_in[cmd.dsel] = count_ff[cmd.dsel] + CNT_W'(1);
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         pos_in  = pos_ff + POS_W'(1);
         fill_in = fill_next;
         if (produce) begin
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff[DQ_MIN]  <= '0;
         head_ff[DQ_MAX]  <= '0;
         count_ff[DQ_MIN] <= '0;
         count_ff[DQ_MAX] <= '0;
         pos_ff           <= '0;
         fill_ff          <= '0;
         win_ff           <= WIN_W'(1);
         rsp_valid_ff     <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         fill_ff      <= fill_in;
         win_ff       <= win_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= req_tdata;
      end
      if (cmd.cap_front) begin
         front_ff[cmd.dsel] <= rd_val;
      end
      if (cmd.finish && produce) begin
         rsp_data_ff <= {front_ff[DQ_MAX], front_ff[DQ_MIN]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== sv/sliding_window_min_max.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Sliding window min/max over signed 32-bit words, one word at a time.
// A new word is accepted only once the previous one is finished. The sequencer evicts aged
// entries and pops dominated entries in each deque, each deque RAM access taking a read state
// and a compare state, and the result word waits until the output register is free.
// Reset (synchronous, active high) empties both deques and sets the window size to 1.
module sliding_window_min_max import swmm_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output      logic                req_tready,
   input  wire logic [DATA_W-1:0]   req_tdata,   // [31:0] sample
   input  wire logic                req_tuser,   // [0] first_of_sequence
   output      logic                rsp_tvalid,
   input  wire logic                rsp_tready,
   output      logic [2*DATA_W-1:0] rsp_tdata,   // [31:0] window_min, [63:32] window_max
   input  wire logic                csr_wr_en,
   input  wire logic [WIN_W-1:0]    csr_wr_data  // window_size
);

   swmm_cmd_type    cmd;
   swmm_status_type status;

   swmm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   swmm_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

endmodule

`default_nettype wire

// ===== tb/sv/sliding_window_min_max_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sliding_window_min_max: streams sample words under several
// window sizes, predicts the windowed minimum and maximum, and compares each result word.
// Depends on swmm_pkg and the sliding_window_min_max top level.
module sliding_window_min_max_tb;
   import swmm_pkg::*;

   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int SETTLE_CYCLES = 320;   // outlasts the worst-case word, with all entries evicted or popped
   localparam int HOLD_CYCLES   = 600;

   typedef struct packed {
      logic signed [DATA_W-1:0] max_val;
      logic signed [DATA_W-1:0] min_val;
   } window_extremes_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [DATA_W-1:0]   req_tdata;
   logic                req_tuser;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [2*DATA_W-1:0] rsp_tdata;
   logic                csr_wr_en;
   logic [WIN_W-1:0]    csr_wr_data;

   // predictor state: one row per deque, oldest entry at index 0
   logic signed [DATA_W-1:0] dq_value [2][WINDOW_MAX];
   logic [POS_W-1:0]         dq_pos   [2][WINDOW_MAX];
   int                       dq_count [2] = '{0, 0};
   logic [POS_W-1:0]         next_position = '0;
   int                       seq_fill = 0;
   logic [WIN_W-1:0]         window_reg = 7'd1;

   window_extremes_type pending_extremes [$];

   int  error_count     = 0;
   int  results_checked = 0;
   int  items_sent      = 0;
   int  windows_written = 0;
   int  cycle_count     = 0;
   bit  idle_enable     = 1'b1;
   bit  hold_rsp_request = 1'b0;

   sliding_window_min_max uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end
   end

   function automatic int span_of(input logic [WIN_W-1:0] size);
      if (size == 0)
         return 1;
      if (size > WINDOW_MAX)
         return WINDOW_MAX;
      return size;
   endfunction

   // Evict stale entries from the front, pop dominated entries from the back, append.
   function automatic void deque_update(input dq_sel_type sel,
                                        input logic signed [DATA_W-1:0] value,
                                        input logic [POS_W-1:0] position, input int span);
      int n;
      int drop;
      bit popping;
      n = dq_count[sel];
      drop = 0;
      while (drop < n && ((position - dq_pos[sel][drop]) & 16'hFFFF) >= span)
         drop++;
      for (int i = 0; i + drop < n; i++) begin
         dq_value[sel][i] = dq_value[sel][i + drop];
         dq_pos[sel][i]   = dq_pos[sel][i + drop];
      end
      n -= drop;
      popping = 1'b1;
      while (n > 0 && popping) begin
         if (sel == DQ_MIN ? dq_value[sel][n - 1] >= value : dq_value[sel][n - 1] <= value)
            n--;
         else
            popping = 1'b0;
      end
      dq_value[sel][n] = value;
      dq_pos[sel][n]   = position;
      dq_count[sel]    = n + 1;
   endfunction

   function automatic bit predict_window(input logic signed [DATA_W-1:0] value,
                                         input logic first_flag,
                                         output window_extremes_type extremes);
      int span;
      span = span_of(window_reg);
      if (first_flag) begin
         dq_count[DQ_MIN] = 0;
         dq_count[DQ_MAX] = 0;
         next_position = '0;
         seq_fill = 0;
      end
      deque_update(DQ_MIN, value, next_position, span);
      deque_update(DQ_MAX, value, next_position, span);
      next_position = next_position + 1'b1;
      if (seq_fill < WINDOW_MAX)
         seq_fill++;
      extremes.min_val = dq_value[DQ_MIN][0];
      extremes.max_val = dq_value[DQ_MAX][0];
      return seq_fill >= span;
   endfunction

   task automatic send_sample(input logic [DATA_W-1:0] value, input logic first_flag);
      window_extremes_type extremes;
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= first_flag;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (predict_window(value, first_flag, extremes))
         pending_extremes.insert(pending_extremes.size(), extremes);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   // Hold the input idle until every expected word has come back.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_extremes.size() != 0);
   endtask

   task automatic set_window(input logic [WIN_W-1:0] size);
      wait_for_results();
      // a word with no result may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= size;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      window_reg = size;
      windows_written++;
   endtask

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_rsp_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp_request = 1'b0;
            rsp_tready <= 1'b1;
         end else if (idle_enable && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      window_extremes_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_extremes.size() == 0) begin
            $display("%0t: unexpected result word: expected none, got min %0d max %0d",
                     $time, $signed(rsp_tdata[31:0]), $signed(rsp_tdata[63:32]));
            error_count++;
         end else begin
            due = pending_extremes.pop_front();
            results_checked++;
            if (rsp_tdata[31:0] !== due.min_val) begin
               $display("%0t: window_min mismatch: expected %0d, got %0d",
                        $time, due.min_val, $signed(rsp_tdata[31:0]));
               error_count++;
            end
            if (rsp_tdata[63:32] !== due.max_val) begin
               $display("%0t: window_max mismatch: expected %0d, got %0d",
                        $time, due.max_val, $signed(rsp_tdata[63:32]));
               error_count++;
            end
         end
      end
   end

   task automatic test_directed_corners();
      set_window(7'd1);
      send_sample(32'h8000_0000, 1'b1);
      send_sample(32'h7FFF_FFFF, 1'b0);
      send_sample(32'h0000_0000, 1'b0);
      send_sample(32'hFFFF_FFFF, 1'b0);
      // zero size behaves as a window of one
      set_window(7'd0);
      send_sample(32'd5, 1'b1);
      send_sample(-32'sd5, 1'b0);
      // first three words fill the window, then equal, rising and falling runs
      set_window(7'd3);
      send_sample(32'd10, 1'b1);
      send_sample(32'd10, 1'b0);
      send_sample(32'd10, 1'b0);
      send_sample(32'd20, 1'b0);
      send_sample(32'd30, 1'b0);
      send_sample(32'd25, 1'b0);
      send_sample(32'd5, 1'b0);
      send_sample(32'd5, 1'b0);
      // shrink mid-sequence: older entries drop from the front
      set_window(7'd2);
      send_sample(32'd7, 1'b0);
      send_sample(-32'sd3, 1'b0);
      // grow mid-sequence: the fill count already covers the new size
      set_window(7'd4);
      send_sample(32'd1, 1'b0);
      send_sample(32'd2, 1'b0);
      send_sample(32'd9, 1'b1);
      send_sample(32'd8, 1'b0);
      send_sample(32'd7, 1'b0);
      send_sample(32'd6, 1'b0);
   endtask

   task automatic test_random_windows();
      logic [WIN_W-1:0]  size;
      logic [DATA_W-1:0] base;
      logic [DATA_W-1:0] value;
      int span;
      int budget;
      int sent;
      int run_len;
      int style;
      int step;
      logic first_flag;
      for (int phase = 0; phase < 12; phase++) begin
         case (phase)
            0: size = 7'd1;
            1: size = 7'd0;
            2: size = 7'd2;
            3: size = 7'd64;
            4: size = 7'd127;
            5: size = 7'd65;
            6: size = 7'd3;
            7: size = WIN_W'($urandom_range(4, 63));
            8: size = WIN_W'($urandom_range(66, 126));
            default: size = WIN_W'($urandom_range(1, 16));
         endcase
         set_window(size);
         span = span_of(size);
         idle_enable = ($urandom_range(0, 3) != 0);
         budget = (span >= 32) ? 130 : 70;
         sent = 0;
         while (sent < budget) begin
            run_len = $urandom_range(1, 3 * span + 4);
            style = $urandom_range(0, 4);
            base = $urandom;
            step = ($urandom_range(0, 6) - 3) * $urandom_range(1, 1000);
            // most runs open a fresh sequence; some carry on the previous one
            first_flag = ($urandom_range(0, 9) != 0);
            for (int k = 0; k < run_len && sent < budget; k++) begin
               case (style)
                  0: value = $urandom;
                  1: value = $urandom_range(0, 6) - 3;
                  2: begin
                     case ($urandom_range(0, 4))
                        0: value = 32'h8000_0000;
                        1: value = 32'h7FFF_FFFF;
                        2: value = 32'h0000_0000;
                        3: value = 32'hFFFF_FFFF;
                        default: value = $urandom;
                     endcase
                  end
                  default: value = base + k * step;
               endcase
               send_sample(value, (k == 0) ? first_flag : ($urandom_range(0, 49) == 0));
               sent++;
            end
         end
      end
      idle_enable = 1'b1;
   endtask

   // Stall the result side long enough for the block to back up onto its input.
   task automatic test_output_backpressure();
      set_window(7'd4);
      idle_enable = 1'b0;
      hold_rsp_request = 1'b1;
      for (int k = 0; k < 50; k++)
         send_sample($urandom, k == 0);
      idle_enable = 1'b1;
   endtask

   task automatic test_drain_pause();
      set_window(7'd6);
      for (int k = 0; k < 15; k++)
         send_sample($urandom, k == 0);
      wait_for_results();
      for (int k = 0; k < 15; k++)
         send_sample($urandom, 1'b0);
   endtask

   task automatic test_steady_tail();
      set_window(7'd5);
      idle_enable = 1'b0;
      for (int k = 0; k < 60; k++)
         send_sample($urandom, k == 0);
   endtask

   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= 1'b0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_directed_corners();
      test_random_windows();
      test_output_backpressure();
      test_drain_pause();
      test_steady_tail();

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d sample words and %0d window results over %0d window settings",
               items_sent, results_checked, windows_written);
      $display("including zero, saturating and mid-sequence sizes, and %0d mismatches",
               error_count);
      if (error_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== sliding_window_min_max.f =====
sv/swmm_pkg.sv
sv/swmm_ram.sv
sv/swmm_ctrl.sv
sv/swmm_datapath.sv
sv/sliding_window_min_max.sv
tb/sv/sliding_window_min_max_tb.sv
